// ===== hw/rtl/tfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types, format codes and channel widening helpers for the texel
// format to BGRA8 converter.
// ----------------------------------------------------------------------------
package tfb_pkg;

	// source format codes
	typedef enum logic [3:0] {
		FMT_BGRA8888    = 4'd0,
		FMT_BGRX8888    = 4'd1,
		FMT_RGBA8888    = 4'd2,
		FMT_RGBX8888    = 4'd3,
		FMT_ABGR8888    = 4'd4,
		FMT_ARGB8888    = 4'd5,
		FMT_RGB888      = 4'd6,
		FMT_RGB888_ALT  = 4'd7,
		FMT_BGR888      = 4'd8,
		FMT_BGR888_ALT  = 4'd9,
		FMT_I8          = 4'd10,
		FMT_IA88        = 4'd11,
		FMT_A8          = 4'd12,
		FMT_RGB565      = 4'd13,
		FMT_BGR565      = 4'd14,
		FMT_UNSUPPORTED = 4'd15
	} tfb_fmt_t;

	localparam logic [7:0] ChanMax = 8'd255;

	// reciprocal factors: floor(x/31) = (x*265)>>13 for x < 256,
	// floor(v/21) = (v*49)>>10 for v < 64
	localparam logic [16:0] Recip31 = 17'd265;
	localparam logic [11:0] Recip21 = 12'd49;

	// one gathered texel group, handed from the gather stage to conversion
	typedef struct packed {
		logic [3:0][7:0] bytes;
		tfb_fmt_t        fmt;
		logic            last;
		logic            err;
	} tfb_group_t;

	// one converted pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       last_pixel;
		logic       format_error;
	} tfb_pixel_t;

	// bytes per texel, zero when there is no converter
	function automatic logic [2:0] group_size(input tfb_fmt_t fmt);
		logic [2:0] size;
		unique case (fmt) inside
			FMT_BGRA8888, FMT_BGRX8888, FMT_RGBA8888, FMT_RGBX8888,
			FMT_ABGR8888, FMT_ARGB8888:                       size = 3'd4;
			FMT_RGB888, FMT_RGB888_ALT, FMT_BGR888, FMT_BGR888_ALT: size = 3'd3;
			FMT_I8, FMT_A8:                                    size = 3'd1;
			FMT_IA88, FMT_RGB565, FMT_BGR565:                  size = 3'd2;
			default:                                           size = 3'd0;
		endcase
		return size;
	endfunction

	// floor(v*255/31) = 8v + floor(7v/31)
	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [7:0]  x7;
		logic [16:0] prod;
		x7   = {v, 3'b000} - {3'b000, v};
		prod = {9'd0, x7} * Recip31;
		return {v, 3'b000} + {5'd0, prod[15:13]};
	endfunction

	// floor(v*255/63) = 4v + floor(v/21)
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [11:0] prod;
		prod = {6'd0, v} * Recip21;
		return {v, 2'b00} + {6'd0, prod[11:10]};
	endfunction

endpackage

// ===== hw/rtl/tfb_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb channel interfaces
// Valid/ready channels for the raw byte stream and the BGRA8 pixel stream.
// ----------------------------------------------------------------------------
interface tfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_image;

	modport source (output valid, output in_byte, output end_of_image, input ready);
	modport sink   (input valid, input in_byte, input end_of_image, output ready);
endinterface

interface tfb_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] alpha;
	logic       last_pixel;
	logic       format_error;

	modport source (output valid, output blue, output green, output red, output alpha,
		output last_pixel, output format_error, input ready);
	modport sink   (input valid, input blue, input green, input red, input alpha,
		input last_pixel, input format_error, output ready);
endinterface

// ===== hw/rtl/texel_format_to_bgra8_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_bgra8_unit
// Converts an uncompressed texel byte stream into BGRA8 pixels.
//
//   channel    dir   carries
//   byte_in    in    in_byte, end_of_image (one raw byte per transfer)
//   pixel_out  out   blue, green, red, alpha, last_pixel, format_error
//   cfg        in    source_format write (cfg_we, cfg_wdata)
//
// One byte per cycle sustained while pixel_out does not stall; a pixel leaves
// once the byte that completes its group has passed the gather and result registers.
// Reset clears the format to BGRA8888, the byte position and both valids.
// A stall on pixel_out holds the result register; byte_in keeps taking
// bytes while stage 1 is free or moving into the result register.
// ----------------------------------------------------------------------------
module texel_format_to_bgra8_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	tfb_byte_if.sink    byte_in,
	tfb_pixel_if.source pixel_out
);
	import tfb_pkg::*;

	logic       group_valid_s1;
	tfb_group_t group_s1;
	tfb_pixel_t pixel_next;
	logic       pixel_valid_s2;
	tfb_pixel_t pixel_s2;
	logic       load_s2;
	logic       advance_s1;
	logic       take;

	// pipeline flow control
	assign load_s2    = group_valid_s1 && (!pixel_valid_s2 || pixel_out.ready);
	assign advance_s1 = !group_valid_s1 || load_s2;
	assign byte_in.ready = advance_s1;
	assign take       = byte_in.valid && advance_s1;

	tfb_gather u_gather (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.take           (take),
		.cur_byte       (byte_in.in_byte),
		.cur_last       (byte_in.end_of_image),
		.advance        (advance_s1),
		.group_valid_s1 (group_valid_s1),
		.group_s1       (group_s1)
	);

	tfb_convert u_convert (
		.group (group_s1),
		.pixel (pixel_next)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_s2 <= 1'b0;
		end else if (load_s2) begin
			pixel_valid_s2 <= 1'b1;
		end else if (pixel_out.ready) begin
			pixel_valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			pixel_s2 <= pixel_next;
		end
	end

	// output transfer
	assign pixel_out.valid        = pixel_valid_s2;
	assign pixel_out.blue         = pixel_s2.blue;
	assign pixel_out.green        = pixel_s2.green;
	assign pixel_out.red          = pixel_s2.red;
	assign pixel_out.alpha        = pixel_s2.alpha;
	assign pixel_out.last_pixel   = pixel_s2.last_pixel;
	assign pixel_out.format_error = pixel_s2.format_error;

endmodule

// ===== hw/rtl/tfb_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_gather
// Holds the format register and the partial texel group, and registers each
// completed group (or the unsupported-format end marker) into stage 1.
// ----------------------------------------------------------------------------
module tfb_gather (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               take,
	input  logic [7:0]         cur_byte,
	input  logic               cur_last,
	input  logic               advance,
	output logic               group_valid_s1,
	output tfb_pkg::tfb_group_t group_s1
);
	import tfb_pkg::*;

	tfb_fmt_t   fmt_q;
	logic [1:0] pos_q;
	logic [7:0] held_q [3];

	logic [2:0] size;
	logic       completes;
	logic       produce;
	tfb_group_t group_next;

	// group decode
	always_comb begin
		size      = group_size(fmt_q);
		completes = (size != 3'd0) && (({1'b0, pos_q} + 3'd1) == size);
		produce   = (size == 3'd0) ? cur_last : completes;
	end

	// assemble the finished group from held bytes and the current byte
	always_comb begin
		group_next.bytes[0] = held_q[0];
		group_next.bytes[1] = held_q[1];
		group_next.bytes[2] = held_q[2];
		group_next.bytes[3] = 8'd0;
		case (size)
			3'd1:    group_next.bytes[0] = cur_byte;
			3'd2:    group_next.bytes[1] = cur_byte;
			3'd3:    group_next.bytes[2] = cur_byte;
			3'd4:    group_next.bytes[3] = cur_byte;
			default: group_next.bytes[0] = held_q[0];
		endcase
		group_next.fmt  = fmt_q;
		group_next.last = cur_last;
		group_next.err  = (size == 3'd0);
	end

	// format register and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_BGRA8888;
			pos_q <= 2'd0;
		end else if (cfg_we) begin
			fmt_q <= tfb_fmt_t'(cfg_wdata);
			pos_q <= 2'd0;
		end else if (take) begin
			if (size == 3'd0 || completes || cur_last) begin
				pos_q <= 2'd0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	// earlier bytes of the current group
	always_ff @(posedge clk) begin
		if (take && size != 3'd0 && !completes) begin
			case (pos_q)
				2'd0:    held_q[0] <= cur_byte;
				2'd1:    held_q[1] <= cur_byte;
				2'd2:    held_q[2] <= cur_byte;
				default: held_q[0] <= held_q[0];
			endcase
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_valid_s1 <= 1'b0;
		end else if (advance) begin
			group_valid_s1 <= take && produce;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (advance && take && produce) begin
			group_s1 <= group_next;
		end
	end

endmodule

// ===== hw/rtl/tfb_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_convert
// Maps one gathered texel group to a BGRA8 pixel: byte swizzles, intensity
// replication, 565 widening and alpha fill.
// ----------------------------------------------------------------------------
module tfb_convert (
	input  tfb_pkg::tfb_group_t group,
	output tfb_pkg::tfb_pixel_t pixel
);
	import tfb_pkg::*;

	logic [15:0] packed565;

	// little-endian 16-bit value for 565 formats
	assign packed565 = {group.bytes[1], group.bytes[0]};

	// channel selection per format
	always_comb begin
		pixel.blue         = 8'd0;
		pixel.green        = 8'd0;
		pixel.red          = 8'd0;
		pixel.alpha        = ChanMax;
		pixel.last_pixel   = group.last;
		pixel.format_error = 1'b0;
		unique case (group.fmt) inside
			FMT_BGRA8888: begin
				pixel.blue  = group.bytes[0];
				pixel.green = group.bytes[1];
				pixel.red   = group.bytes[2];
				pixel.alpha = group.bytes[3];
			end
			FMT_BGRX8888, FMT_BGR888, FMT_BGR888_ALT: begin
				pixel.blue  = group.bytes[0];
				pixel.green = group.bytes[1];
				pixel.red   = group.bytes[2];
			end
			FMT_RGBA8888: begin
				pixel.blue  = group.bytes[2];
				pixel.green = group.bytes[1];
				pixel.red   = group.bytes[0];
				pixel.alpha = group.bytes[3];
			end
			FMT_RGBX8888, FMT_RGB888, FMT_RGB888_ALT: begin
				pixel.blue  = group.bytes[2];
				pixel.green = group.bytes[1];
				pixel.red   = group.bytes[0];
			end
			FMT_ABGR8888: begin
				pixel.blue  = group.bytes[1];
				pixel.green = group.bytes[2];
				pixel.red   = group.bytes[3];
				pixel.alpha = group.bytes[0];
			end
			FMT_ARGB8888: begin
				pixel.blue  = group.bytes[3];
				pixel.green = group.bytes[2];
				pixel.red   = group.bytes[1];
				pixel.alpha = group.bytes[0];
			end
			FMT_I8: begin
				pixel.blue  = group.bytes[0];
				pixel.green = group.bytes[0];
				pixel.red   = group.bytes[0];
			end
			FMT_IA88: begin
				pixel.blue  = group.bytes[0];
				pixel.green = group.bytes[0];
				pixel.red   = group.bytes[0];
				pixel.alpha = group.bytes[1];
			end
			FMT_A8: begin
				pixel.blue  = ChanMax;
				pixel.green = ChanMax;
				pixel.red   = ChanMax;
				pixel.alpha = group.bytes[0];
			end
			FMT_RGB565: begin
				pixel.red   = widen5(packed565[15:11]);
				pixel.green = widen6(packed565[10:5]);
				pixel.blue  = widen5(packed565[4:0]);
			end
			FMT_BGR565: begin
				pixel.blue  = widen5(packed565[15:11]);
				pixel.green = widen6(packed565[10:5]);
				pixel.red   = widen5(packed565[4:0]);
			end
			default: begin
				pixel.alpha        = 8'd0;
				pixel.last_pixel   = 1'b1;
				pixel.format_error = 1'b1;
			end
		endcase
		// no converter: all colors zero
		if (group.err) begin
			pixel.blue         = 8'd0;
			pixel.green        = 8'd0;
			pixel.red          = 8'd0;
			pixel.alpha        = 8'd0;
			pixel.last_pixel   = 1'b1;
			pixel.format_error = 1'b1;
		end
	end

endmodule

// ===== hw/rtl/tfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_checker
// Port-level checks for the texel format converter, bound to the top level.
// ----------------------------------------------------------------------------
module tfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] blue,
	input logic [7:0] green,
	input logic [7:0] red,
	input logic [7:0] alpha,
	input logic       last_pixel,
	input logic       format_error
);

	// a stalled pixel stays offered
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel valid dropped while stalled");

	// a stalled pixel keeps its value
	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({blue, green, red, alpha, last_pixel,
			format_error}))
		else $error("pixel payload changed while stalled");

	// an error result is the zeroed end marker
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error |-> last_pixel && blue == 8'd0 && green == 8'd0
			&& red == 8'd0 && alpha == 8'd0)
		else $error("format error result not zeroed end marker");

	// a fresh pixel follows a byte transfer, registered through stage 1 and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("pixel appeared without a byte transfer");

endmodule

bind texel_format_to_bgra8_unit tfb_checker u_tfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_in.valid),
	.in_ready     (byte_in.ready),
	.out_valid    (pixel_out.valid),
	.out_ready    (pixel_out.ready),
	.blue         (pixel_out.blue),
	.green        (pixel_out.green),
	.red          (pixel_out.red),
	.alpha        (pixel_out.alpha),
	.last_pixel   (pixel_out.last_pixel),
	.format_error (pixel_out.format_error)
);

// ===== tb/texel_format_to_bgra8_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_bgra8_unit_tb
// Self-checking bench for the texel to BGRA8 converter. A short directed
// list hits the reset format, channel extremes, 565 widening, a dropped
// partial group and the unsupported-format error. Random images in random
// source formats follow, with sender and receiver idling. Every pixel transfer
// is checked against an in-bench converter model or a hand-typed expectation.
// ----------------------------------------------------------------------------
module texel_format_to_bgra8_unit_tb;
	import tfb_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned RAND_SEGMENTS = 24;
	localparam int unsigned SEG_BYTES     = 21;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned TIMEOUT_NS    = 5_000_000;

	typedef enum logic {
		ROW_FORMAT,
		ROW_BYTE
	} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [7:0] data;
		logic       eoi;
		bit         typed;
		tfb_pixel_t pix;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	tfb_byte_if  byte_ch ();
	tfb_pixel_if pix_ch ();

	texel_format_to_bgra8_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_ch),
		.pixel_out (pix_ch)
	);

	// converter model state
	tfb_fmt_t   fmt_model;
	logic [1:0] pos_model;
	logic [7:0] held_model [3];

	tfb_pixel_t  pending_pixels [$];
	stim_row_t   dir_rows [$];
	int unsigned mismatch_count = 0;

	// hand-typed expectation for the byte on offer
	bit          row_typed;
	tfb_pixel_t  row_pix;

	bit          offering = 1'b0;
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct  = 0;
	bit          hold_req        = 1'b0;
	int unsigned hold_left       = 0;

	always #6 clk = ~clk;

	function automatic int unsigned texel_bytes(input tfb_fmt_t f);
		case (f)
			FMT_BGRA8888, FMT_BGRX8888, FMT_RGBA8888, FMT_RGBX8888,
			FMT_ABGR8888, FMT_ARGB8888: return 4;
			FMT_RGB888, FMT_RGB888_ALT, FMT_BGR888, FMT_BGR888_ALT: return 3;
			FMT_IA88, FMT_RGB565, FMT_BGR565: return 2;
			FMT_I8, FMT_A8: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] expand5(input logic [4:0] v);
		int unsigned w;
		w = v;
		return 8'((w * 255) / 31);
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] v);
		int unsigned w;
		w = v;
		return 8'((w * 255) / 63);
	endfunction

	// step the model by one byte, report the pixel it completes if any
	function automatic void convert_texel_byte(input logic [7:0] cur, input logic eoi,
		output bit produced, output tfb_pixel_t pix);
		int unsigned tsize;
		logic [7:0]  s [4];
		logic [15:0] p;
		produced = 1'b0;
		pix      = '0;
		tsize    = texel_bytes(fmt_model);
		// no converter: only the end byte reports, as an error
		if (tsize == 0) begin
			pos_model = '0;
			if (eoi) begin
				produced         = 1'b1;
				pix.last_pixel   = 1'b1;
				pix.format_error = 1'b1;
			end
			return;
		end
		// group still open: hold the byte, a marked end drops the group
		if (pos_model + 1 < tsize) begin
			held_model[pos_model] = cur;
			pos_model = eoi ? 2'd0 : pos_model + 2'd1;
			return;
		end
		for (int i = 0; i < 3; i++)
			s[i] = held_model[i];
		s[tsize - 1] = cur;
		s[3] = (tsize == 4) ? cur : 8'h00;
		pos_model = '0;
		p = {s[1], s[0]};
		produced       = 1'b1;
		pix.alpha      = 8'hFF;
		pix.last_pixel = eoi;
		case (fmt_model)
			FMT_BGRA8888: begin
				pix.blue = s[0]; pix.green = s[1]; pix.red = s[2]; pix.alpha = s[3];
			end
			FMT_BGRX8888, FMT_BGR888, FMT_BGR888_ALT: begin
				pix.blue = s[0]; pix.green = s[1]; pix.red = s[2];
			end
			FMT_RGBA8888: begin
				pix.blue = s[2]; pix.green = s[1]; pix.red = s[0]; pix.alpha = s[3];
			end
			FMT_RGBX8888, FMT_RGB888, FMT_RGB888_ALT: begin
				pix.blue = s[2]; pix.green = s[1]; pix.red = s[0];
			end
			FMT_ABGR8888: begin
				pix.blue = s[1]; pix.green = s[2]; pix.red = s[3]; pix.alpha = s[0];
			end
			FMT_ARGB8888: begin
				pix.blue = s[3]; pix.green = s[2]; pix.red = s[1]; pix.alpha = s[0];
			end
			FMT_I8: begin
				pix.blue = s[0]; pix.green = s[0]; pix.red = s[0];
			end
			FMT_IA88: begin
				pix.blue = s[0]; pix.green = s[0]; pix.red = s[0]; pix.alpha = s[1];
			end
			FMT_A8: begin
				pix.blue = 8'hFF; pix.green = 8'hFF; pix.red = 8'hFF; pix.alpha = s[0];
			end
			FMT_RGB565: begin
				pix.red   = expand5(p[15:11]);
				pix.green = expand6(p[10:5]);
				pix.blue  = expand5(p[4:0]);
			end
			default: begin
				pix.blue  = expand5(p[15:11]);
				pix.green = expand6(p[10:5]);
				pix.red   = expand5(p[4:0]);
			end
		endcase
	endfunction

	// directed list builders
	function automatic void fmt_row(input tfb_fmt_t f);
		stim_row_t r;
		r = '{kind: ROW_FORMAT, data: 8'(f), eoi: 1'b0, typed: 1'b0, pix: '0};
		dir_rows.push_back(r);
	endfunction

	function automatic void byte_row(input logic [7:0] d, input logic eoi);
		stim_row_t r;
		r = '{kind: ROW_BYTE, data: d, eoi: eoi, typed: 1'b0, pix: '0};
		dir_rows.push_back(r);
	endfunction

	function automatic void known_row(input logic [7:0] d, input logic eoi,
		input logic [7:0] b, input logic [7:0] g, input logic [7:0] r8,
		input logic [7:0] a, input logic last, input logic err);
		stim_row_t r;
		r = '{kind: ROW_BYTE, data: d, eoi: eoi, typed: 1'b1, pix: '0};
		r.pix.blue         = b;
		r.pix.green        = g;
		r.pix.red          = r8;
		r.pix.alpha        = a;
		r.pix.last_pixel   = last;
		r.pix.format_error = err;
		dir_rows.push_back(r);
	endfunction

	// drop valid if it is up, land on the next falling edge
	task automatic release_bus();
		if (offering) begin
			byte_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		@(negedge clk);
	endtask

	// offer one byte after a random gap, return on the falling edge after the transfer
	task automatic send_byte(input logic [7:0] data, input logic eoi, input bit typed,
		input tfb_pixel_t pix);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			if (offering) begin
				byte_ch.valid <= 1'b0;
				offering = 1'b0;
			end
			@(negedge clk);
		end
		row_typed = typed;
		row_pix   = pix;
		byte_ch.valid        <= 1'b1;
		byte_ch.in_byte      <= data;
		byte_ch.end_of_image <= eoi;
		offering = 1'b1;
		do @(posedge clk); while (!byte_ch.ready);
		@(negedge clk);
	endtask

	// format write only once the block has drained
	task automatic change_format(input tfb_fmt_t f);
		release_bus();
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		fmt_model = f;
		pos_model = '0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			pix_ch.ready <= 1'b0;
		end else begin
			pix_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// predict on each byte transfer, check each pixel transfer
	always @(posedge clk) begin
		bit         hit;
		tfb_pixel_t calc;
		tfb_pixel_t got;
		tfb_pixel_t want;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				convert_texel_byte(byte_ch.in_byte, byte_ch.end_of_image, hit, calc);
				if (hit)
					pending_pixels.push_back(row_typed ? row_pix : calc);
			end
			if (pix_ch.valid && pix_ch.ready) begin
				got.blue         = pix_ch.blue;
				got.green        = pix_ch.green;
				got.red          = pix_ch.red;
				got.alpha        = pix_ch.alpha;
				got.last_pixel   = pix_ch.last_pixel;
				got.format_error = pix_ch.format_error;
				if (pending_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t unexpected pixel", $realtime,
							" b=%02h g=%02h r=%02h a=%02h last=%0b err=%0b",
							got.blue, got.green, got.red, got.alpha,
							got.last_pixel, got.format_error);
				end else begin
					want = pending_pixels.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t pixel mismatch", $realtime,
								" exp b=%02h g=%02h r=%02h a=%02h last=%0b err=%0b,",
								want.blue, want.green, want.red, want.alpha,
								want.last_pixel, want.format_error,
								" got b=%02h g=%02h r=%02h a=%02h last=%0b err=%0b",
								got.blue, got.green, got.red, got.alpha,
								got.last_pixel, got.format_error);
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		tfb_fmt_t    f;
		int unsigned tsize;
		int unsigned len;
		int unsigned sent;
		bit          paused;
		bit          with_end;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		byte_ch.valid        = 1'b0;
		byte_ch.in_byte      = '0;
		byte_ch.end_of_image = 1'b0;
		pix_ch.ready         = 1'b0;
		fmt_model            = FMT_BGRA8888;
		pos_model            = '0;
		for (int i = 0; i < 3; i++)
			held_model[i] = '0;
		row_typed = 1'b0;
		row_pix   = '0;

		// reset format is BGRA8888: bytes map straight to b, g, r, a
		byte_row(8'h00, 1'b0);
		byte_row(8'hFF, 1'b0);
		byte_row(8'h00, 1'b0);
		known_row(8'hFF, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
		// partial group, dropped by the format write
		byte_row(8'h5A, 1'b0);
		fmt_row(FMT_RGB565);
		byte_row(8'hFF, 1'b0);
		known_row(8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
		byte_row(8'h1F, 1'b0);
		byte_row(8'hF8, 1'b0);
		fmt_row(FMT_BGR565);
		byte_row(8'h00, 1'b0);
		known_row(8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);
		fmt_row(FMT_I8);
		known_row(8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
		fmt_row(FMT_A8);
		known_row(8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0);
		fmt_row(FMT_IA88);
		byte_row(8'h80, 1'b0);
		byte_row(8'h7F, 1'b1);
		// image ends inside a group: nothing comes out for that group
		fmt_row(FMT_RGB888);
		byte_row(8'h11, 1'b0);
		byte_row(8'h22, 1'b1);
		byte_row(8'h33, 1'b0);
		byte_row(8'h44, 1'b0);
		byte_row(8'h55, 1'b1);
		fmt_row(FMT_ARGB8888);
		byte_row(8'h01, 1'b0);
		byte_row(8'h02, 1'b0);
		byte_row(8'h03, 1'b0);
		byte_row(8'h04, 1'b1);
		// no converter: silent until the end byte, which reports the error
		fmt_row(FMT_UNSUPPORTED);
		byte_row(8'hAB, 1'b0);
		known_row(8'hCD, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed walk, no idling
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_FORMAT)
				change_format(tfb_fmt_t'(dir_rows[i].data[3:0]));
			else
				send_byte(dir_rows[i].data, dir_rows[i].eoi, dir_rows[i].typed,
					dir_rows[i].pix);
		end

		// random images, idling mode rotates per segment
		for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			if (seg == 0)
				f = FMT_BGRA8888;
			else if (seg == 1)
				f = FMT_UNSUPPORTED;
			else if (seg == 4)
				f = FMT_I8;
			else
				f = tfb_fmt_t'(4'($urandom_range(0, 15)));
			change_format(f);
			tsize = texel_bytes(f);
			// one pixel per byte with no idling: a long hold backs up the input
			if (seg == 4)
				hold_req = 1'b1;
			sent   = 0;
			paused = 1'b0;
			while (sent < SEG_BYTES) begin
				// sender waits for the pipeline to empty
				if (seg % 8 == 6 && !paused && sent >= SEG_BYTES / 2) begin
					release_bus();
					while (pending_pixels.size() != 0)
						@(negedge clk);
					paused = 1'b1;
				end
				if (tsize == 0) begin
					len = $urandom_range(1, 6);
				end else begin
					len = tsize * $urandom_range(1, 4);
					if ($urandom_range(0, 99) < 15)
						len = $urandom_range(1, len + tsize - 1);
				end
				with_end = ($urandom_range(0, 99) >= 10);
				for (int k = 0; k < len; k++)
					send_byte(8'($urandom_range(0, 255)), with_end && (k == len - 1),
						1'b0, '0);
				sent += len;
			end
		end

		// drain
		release_bus();
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES * 4) @(negedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
